FILE: rtl/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg: shared types and constants for the linear probing hash set
// Slot store geometry, key limits, request/response codes and FSM states.
// ----------------------------------------------------------------------------
package lphs_pkg;

   localparam int unsigned MaxSlots    = 2048;
   localparam int unsigned MaxKeyBytes = 8;
   localparam int unsigned SlotBits    = $clog2(MaxSlots);
   localparam int unsigned SizeBits    = 12;
   localparam int unsigned KeyBits     = 8 * MaxKeyBytes;
   localparam int unsigned LenBits     = 4;
   localparam int unsigned CountBits   = 12;
   localparam int unsigned HashBits    = 32;
   localparam logic [SizeBits-1:0]  SizeReset = 12'd2011;
   localparam logic [CountBits-1:0] CountMax  = '1;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_PLACED  = 2'd0,
      STATUS_PRESENT = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // slot store write command from control to store
   typedef struct packed {
      logic                wr_en;
      logic [SlotBits-1:0] addr;
      logic [KeyBits-1:0]  key;
      logic [LenBits-1:0]  len;
   } store_cmd_type;

   // one slot as read back
   typedef struct packed {
      logic               used;
      logic [KeyBits-1:0] key;
      logic [LenBits-1:0] len;
   } slot_type;

endpackage

FILE: rtl/lphs_req_if.sv
// ----------------------------------------------------------------------------
// lphs_req_if: request channel
// Valid/ready transfer of one key with insert/lookup kind.
// ----------------------------------------------------------------------------
interface lphs_req_if;
   import lphs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [KeyBits-1:0]    key_bytes;
   logic [LenBits-1:0]    key_length;
   modport source (output valid, kind, key_bytes, key_length, input ready);
   modport sink   (input valid, kind, key_bytes, key_length, output ready);
endinterface

FILE: rtl/lphs_rsp_if.sv
// ----------------------------------------------------------------------------
// lphs_rsp_if: response channel
// Valid/ready transfer of one lookup or insert outcome.
// ----------------------------------------------------------------------------
interface lphs_rsp_if;
   import lphs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [1:0]            status;
   logic [SlotBits-1:0]   position;
   modport source (output valid, found, status, position, input ready);
   modport sink   (input valid, found, status, position, output ready);
endinterface

FILE: rtl/lphs_slot_store.sv
// ----------------------------------------------------------------------------
// lphs_slot_store: slot memory
// Key/length RAM plus a used-flag RAM cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module lphs_slot_store
   import lphs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  store_cmd_type       cmd,
   input  logic [SlotBits-1:0] rd_addr,
   output slot_type            rd_data,
   output logic                clear_done
);

   logic [KeyBits+LenBits-1:0] data_mem [MaxSlots];
   logic                       used_mem [MaxSlots];
   logic [KeyBits+LenBits-1:0] data_q;
   logic                       used_q;
   logic [SlotBits:0]          clr_ff;
   logic [SlotBits:0]          clr_in;

   assign clear_done = clr_ff[SlotBits];
   assign clr_in     = clear_done ? clr_ff : clr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         data_mem[cmd.addr] <= {cmd.key, cmd.len};
      end
      data_q <= data_mem[rd_addr];
   end

   // used flags: cleared by the sweep, set on insert
   always_ff @(posedge clock) begin
      if (!clear_done) begin
         used_mem[clr_ff[SlotBits-1:0]] <= 1'b0;
      end else if (cmd.wr_en) begin
         used_mem[cmd.addr] <= 1'b1;
      end
      used_q <= used_mem[rd_addr];
   end

   assign rd_data = '{used: used_q, key: data_q[KeyBits+LenBits-1:LenBits],
                      len: data_q[LenBits-1:0]};

endmodule

FILE: rtl/lphs_ctrl.sv
// ----------------------------------------------------------------------------
// lphs_ctrl: probe sequencer
// Hash one byte a cycle, reduce modulo size bit-serially, walk the slots.
// ----------------------------------------------------------------------------
module lphs_ctrl
   import lphs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_done,
   input  logic [SizeBits-1:0]  table_size,
   lphs_req_if.sink             req,
   lphs_rsp_if.source           rsp,
   output logic [SlotBits-1:0]  rd_addr,
   input  slot_type             rd_data,
   output store_cmd_type        cmd
);

   state_type               state_ff, state_in;
   logic                    kind_ff, kind_in;
   logic [KeyBits-1:0]      key_ff, key_in;
   logic [LenBits-1:0]      len_ff, len_in;
   logic [LenBits-1:0]      idx_ff, idx_in;
   logic [HashBits-1:0]     hash_ff, hash_in;
   logic [SizeBits:0]       size_ff, size_in;
   logic [5:0]              bit_ff, bit_in;
   logic [SizeBits:0]       rem_ff, rem_in;
   logic [SlotBits-1:0]     pos_ff, pos_in;
   logic [SizeBits:0]       steps_ff, steps_in;
   logic [CountBits-1:0]    count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   status_type              status_ff, status_in;
   logic [SlotBits-1:0]     position_ff, position_in;

   logic [LenBits-1:0]      len_clip;
   logic [KeyBits-1:0]      key_mask;
   logic [7:0]              cur_byte;
   logic [SizeBits+1:0]     rem_shift;
   logic [SizeBits:0]       eff_size;
   logic [SizeBits:0]       pos_next;
   logic                    match;
   logic                    rsp_free;

   always_comb begin
      eff_size = {1'b0, table_size};
      if (table_size == '0) eff_size = 13'd1;
      if (table_size > SizeBits'(MaxSlots)) eff_size = 13'(MaxSlots);
   end

   assign len_clip = (req.key_length > LenBits'(MaxKeyBytes)) ?
                     LenBits'(MaxKeyBytes) : req.key_length;
   always_comb begin
      key_mask = '0;
      for (int i = 0; i < MaxKeyBytes; i++) begin
         if (LenBits'(i) < len_clip) key_mask[8*i +: 8] = 8'hFF;
      end
   end

   assign cur_byte  = key_ff[{idx_ff[2:0], 3'b000} +: 8];
   assign rem_shift = {rem_ff, hash_ff[5'(bit_ff)]};
   assign pos_next  = {2'b0, pos_ff} + 1'b1;
   assign match     = rd_data.len == len_ff && rd_data.key == key_ff;
   // the response register is free when empty or emptied at this edge
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign rd_addr   = pos_ff;
   assign req.ready = state_ff == ST_IDLE && clear_done;
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.found    = found_ff;
   assign rsp.status   = status_ff;
   assign rsp.position = position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      hash_ff     <= hash_in;
      size_ff     <= size_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      steps_ff    <= steps_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   always_comb begin
      state_in = state_ff;   kind_in = kind_ff;   key_in = key_ff;
      len_in = len_ff;       idx_in = idx_ff;     hash_in = hash_ff;
      size_in = size_ff;     bit_in = bit_ff;     rem_in = rem_ff;
      pos_in = pos_ff;       steps_in = steps_ff; count_in = count_ff;
      found_in = found_ff;   status_in = status_ff;
      position_in = position_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      cmd = '{wr_en: 1'b0, addr: pos_ff, key: key_ff, len: len_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               kind_in  = req.kind;
               key_in   = req.key_bytes & key_mask;
               len_in   = len_clip;
               idx_in   = '0;
               hash_in  = '0;
               size_in  = eff_size;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (idx_ff == len_ff) begin
               bit_in   = 6'(HashBits - 1);
               rem_in   = '0;
               state_in = ST_MOD;
            end else begin
               hash_in = (hash_ff << 5) + (hash_ff << 2) + hash_ff
                       + {{24{cur_byte[7]}}, cur_byte};
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_MOD: begin
            // restoring division, one quotient bit a cycle
            rem_in = (rem_shift >= {1'b0, size_ff}) ?
                     SizeBits'(rem_shift - {1'b0, size_ff}) + 13'd0 :
                     rem_shift[SizeBits:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               // home slot: present its address in ST_READ, check the registered data in ST_CHECK
               pos_in   = rem_in[SlotBits-1:0];
               steps_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (steps_ff != size_ff && rd_data.used && !match) begin
               // advance one slot, wrapping at the size; wait for the read
               pos_in   = (pos_next == size_ff) ? '0 : pos_ff + 1'b1;
               steps_in = steps_ff + 1'b1;
               state_in = ST_READ;
            end else if (rsp_free) begin
               state_in = ST_DONE;
               found_in = 1'b0;  status_in = STATUS_PLACED;  position_in = '0;
               if (steps_ff == size_ff) begin
                  if (kind_ff == KIND_INSERT) status_in = STATUS_FULL;
               end else if (!rd_data.used) begin
                  if (kind_ff == KIND_INSERT) begin
                     if ({count_ff, 1'b0} > {1'b0, size_ff}) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cmd.wr_en   = 1'b1;
                        position_in = pos_ff;
                        if (count_ff != CountMax) count_in = count_ff + 1'b1;
                     end
                  end
               end else begin
                  found_in    = 1'b1;
                  position_in = pos_ff;
                  if (kind_ff == KIND_INSERT) status_in = STATUS_PRESENT;
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/linear_probe_hash_set.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set: open-addressing key set with linear probing
// Inserts or looks up keys of up to eight bytes in a slot RAM.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          payload
//   req_     in   valid/ready        kind, key_bytes, key_length
//   rsp_     out  valid/ready        found, status, position
//   csr_     in   write enable only  table_size (12 bits)
//
// One request at a time: the key is hashed byte by byte, the hash is reduced
// modulo the table size bit-serially, then each examined slot is read from
// the RAM (registered read) and checked, and the response register is loaded;
// the next request is taken once the sequencer is back in idle.
// After reset a sweep clears the used flags; no request is taken meanwhile.
// A held response stalls the walk at its last slot.
module linear_probe_hash_set
   import lphs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   lphs_req_if.sink            req,
   lphs_rsp_if.source          rsp,
   input  logic                csr_wr_en,
   input  logic [SizeBits-1:0] csr_wr_data
);

   logic [SizeBits-1:0] size_ff;
   logic [SlotBits-1:0] rd_addr;
   slot_type            rd_data;
   store_cmd_type       cmd;
   logic                clear_done;

   // hold the configured size
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeReset;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   lphs_slot_store u_store (
      .clock, .reset, .cmd, .rd_addr, .rd_data, .clear_done
   );

   lphs_ctrl u_ctrl (
      .clock, .reset, .clear_done, .table_size(size_ff),
      .req, .rsp, .rd_addr, .rd_data, .cmd
   );

`ifndef NO_ASSERTIONS
   // an insert write is followed by a placed response
   a_write_then_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |=> ##1 (rsp.valid && rsp.status == STATUS_PLACED))
      else $error("insert write without placed response");
   // no request accepted during the clearing sweep
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !req.ready)
      else $error("request ready during clear");
   // no write during the clearing sweep
   a_no_wr_clear: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !cmd.wr_en)
      else $error("write during clear");
`endif

endmodule

FILE: test/linear_probe_hash_set_checker.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_checker: response predictor and scoreboard
// Watches request and response transfers, keeps a shadow slot table and
// compares each response field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_checker
   import lphs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   lphs_req_if.sink            req,
   lphs_rsp_if.sink            rsp,
   input  logic                csr_wr_en,
   input  logic [SizeBits-1:0] csr_wr_data,
   output int                  fail_count,
   output int                  pending_count
);

   typedef struct packed {
      logic                found;
      status_type          status;
      logic [SlotBits-1:0] position;
   } outcome_type;

   logic [KeyBits-1:0]   shadow_key [MaxSlots];
   logic [LenBits-1:0]   shadow_len [MaxSlots];
   logic                 shadow_used [MaxSlots];
   logic [CountBits-1:0] shadow_count;
   logic [SizeBits-1:0]  shadow_size;
   outcome_type          expected_outcomes [$];

   assign pending_count = expected_outcomes.size();

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic outcome_type predict_outcome(input logic kind,
         input logic [KeyBits-1:0] raw_key, input logic [LenBits-1:0] raw_len);
      int unsigned n, len, pos;
      logic [31:0] h, b;
      logic [KeyBits-1:0] key;
      bit hit, empty;
      outcome_type o;
      len = (raw_len > MaxKeyBytes) ? MaxKeyBytes : raw_len;
      key = '0;
      h = '0;
      for (int i = 0; i < len; i++) begin
         key[8*i +: 8] = raw_key[8*i +: 8];
         b = {{24{raw_key[8*i+7]}}, raw_key[8*i +: 8]};
         h = 32'd37 * h + b;
      end
      n = (shadow_size == 0) ? 1 : ((shadow_size > MaxSlots) ? MaxSlots : shadow_size);
      pos = h % n;
      hit = 0;
      empty = 0;
      for (int s = 0; s < n; s++) begin
         if (!shadow_used[pos]) begin
            empty = 1;
            break;
         end
         if (shadow_len[pos] == len && shadow_key[pos] == key) begin
            hit = 1;
            break;
         end
         pos = (pos + 1) % n;
      end
      o = '{found: hit, status: STATUS_PLACED, position: hit ? SlotBits'(pos) : '0};
      if (kind == KIND_LOOKUP) return o;
      if (hit) begin
         o.status = STATUS_PRESENT;
         return o;
      end
      if (2 * shadow_count > n || !empty) begin
         o.status = STATUS_FULL;
         o.position = '0;
         return o;
      end
      shadow_key[pos] = key;
      shadow_len[pos] = LenBits'(len);
      shadow_used[pos] = 1'b1;
      if (shadow_count != CountMax) shadow_count++;
      o.position = SlotBits'(pos);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         for (int i = 0; i < MaxSlots; i++) shadow_used[i] = 1'b0;
         shadow_count = '0;
         shadow_size = SizeReset;
         expected_outcomes.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) shadow_size = csr_wr_data;
         if (req.valid && req.ready)
            expected_outcomes.push_back(predict_outcome(req.kind, req.key_bytes,
                                                        req.key_length));
         if (rsp.valid && rsp.ready) begin
            got = '{found: rsp.found, status: status_type'(rsp.status),
                    position: rsp.position};
            if (expected_outcomes.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_outcomes.pop_front();
               if (got.found !== want.found)
                  report_mismatch($sformatf("found %b, want %b", got.found, want.found));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", got.status,
                                            want.status));
               if (got.position !== want.position)
                  report_mismatch($sformatf("position %0d, want %0d", got.position,
                                            want.position));
            end
         end
      end
   end

endmodule

FILE: test/linear_probe_hash_set_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_tb: stimulus and verdict for the hash set
// Drives directed and random inserts and lookups over several table sizes
// and idle patterns; a checker module beside the block scores responses.
// ----------------------------------------------------------------------------
module linear_probe_hash_set_tb;
   import lphs_pkg::*;

   localparam int StallLimit = 20000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [SizeBits-1:0] csr_wr_data = '0;
   int                  fail_count;
   int                  pending_count;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  quiet_cycles = 0;

   lphs_req_if req_ch ();
   lphs_rsp_if rsp_ch ();

   // recent keys, replayed so lookups and re-inserts hit stored entries
   logic [KeyBits-1:0] key_pool [$];
   logic [LenBits-1:0] len_pool [$];

   linear_probe_hash_set u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   linear_probe_hash_set_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch.sink),
      .rsp           (rsp_ch.sink),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_INSERT;
      req_ch.key_bytes = '0;
      req_ch.key_length = '0;
      rsp_ch.ready = 1'b0;
   end

   // stall the response side at the current rate
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // present one request and hold it until the transfer; insert a random gap
   task automatic send_request(input logic kind, input logic [KeyBits-1:0] key,
                               input logic [LenBits-1:0] len);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.key_bytes <= key;
      req_ch.key_length <= len;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (len != 0) begin
         key_pool.push_back(key);
         len_pool.push_back(len);
         if (key_pool.size() > 64) begin
            void'(key_pool.pop_front());
            void'(len_pool.pop_front());
         end
      end
   endtask

   // drain, let the block settle, then write the table size
   task automatic set_table_size(input logic [SizeBits-1:0] size);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly short keys over a small alphabet so collisions and repeats occur
   task automatic random_request();
      logic [KeyBits-1:0] key;
      logic [LenBits-1:0] len;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40 && key_pool.size() > 0) begin
         int unsigned j;
         j = $urandom_range(key_pool.size() - 1);
         key = key_pool[j];
         len = len_pool[j];
         if ($urandom_range(3) == 0) key = key ^ ({$urandom, $urandom} << (8 * len));
      end else if (pick < 85) begin
         len = LenBits'($urandom_range(8, 1));
         key = {$urandom, $urandom};
         for (int i = 0; i < 8; i++) key[8*i +: 8] = 8'(8'h61 + (key[8*i +: 8] % 4));
      end else begin
         len = LenBits'($urandom_range(15));
         key = {$urandom, $urandom};
      end
      send_request(1'($urandom_range(1)), key, len);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty and extreme keys, both kinds, repeats, long length
      send_request(KIND_LOOKUP, 64'h0, 4'd0);
      send_request(KIND_INSERT, 64'h0, 4'd0);
      send_request(KIND_INSERT, 64'h0, 4'd0);
      send_request(KIND_LOOKUP, 64'h0, 4'd0);
      send_request(KIND_INSERT, '1, 4'd8);
      send_request(KIND_INSERT, '1, 4'd15);
      send_request(KIND_LOOKUP, '1, 4'd8);
      send_request(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FF80, 4'd1);
      send_request(KIND_LOOKUP, 64'h80, 4'd1);
      send_request(KIND_INSERT, 64'h5555_5555_5555_5555, 4'd9);
      send_request(KIND_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8);
      send_request(KIND_INSERT, 64'h0000_0000_0000_0061, 4'd2);
      send_request(KIND_LOOKUP, 64'h0000_0000_0000_0061, 4'd1);

      // tiny tables: refusal at half full, zero size, shrink over entries
      set_table_size(12'd4);
      for (int i = 0; i < 6; i++) send_request(KIND_INSERT, 64'h41 + i, 4'd1);
      set_table_size(12'd0);
      send_request(KIND_INSERT, 64'h7A, 4'd1);
      send_request(KIND_LOOKUP, 64'h41, 4'd1);
      set_table_size(12'hFFF);
      send_request(KIND_LOOKUP, 64'h41, 4'd1);

      // random phases: table size, sender idle and receiver stall rates
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_table_size(12'd2048);
            1: set_table_size(12'd1);
            2: set_table_size(12'd7);
            3: set_table_size(12'd2011);
            4: set_table_size(12'd64);
            5: set_table_size(12'd3000);
            6: set_table_size(12'd16);
            default: set_table_size(12'd2048);
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         repeat (235) random_request();
      end

      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: linear_probe_hash_set.f
rtl/lphs_pkg.sv
rtl/lphs_req_if.sv
rtl/lphs_rsp_if.sv
rtl/lphs_slot_store.sv
rtl/lphs_ctrl.sv
rtl/linear_probe_hash_set.sv
test/linear_probe_hash_set_checker.sv
test/linear_probe_hash_set_tb.sv
